### sv/imu_complementary_tilt_filter_assert.svh
// Assertion macros for the tilt filter checker
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_ASSERT_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_ASSERT_SVH
`define ICTF_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define ICTF_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

### sv/ictf_pkg.sv
// Shared types and constants for the tilt filter
package ictf_pkg;
  localparam int TableSize = 24;
  localparam logic [63:0] Q24Deg180 = 64'd3019898880;

  typedef enum logic [2:0] {
    ST_IDLE, ST_GMUL, ST_GDIV, ST_CORDIC, ST_BLEND, ST_OUT
  } state_t;

  function automatic logic [31:0] atan_q24(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd754974720;  5'd1: r = 32'd445687602;
      5'd2: r = 32'd235489088;  5'd3: r = 32'd119537938;
      5'd4: r = 32'd60000934;   5'd5: r = 32'd30029717;
      5'd6: r = 32'd15018523;   5'd7: r = 32'd7509720;
      5'd8: r = 32'd3754917;    5'd9: r = 32'd1877466;
      5'd10: r = 32'd938734;    5'd11: r = 32'd469367;
      5'd12: r = 32'd234684;    5'd13: r = 32'd117342;
      5'd14: r = 32'd58671;     5'd15: r = 32'd29335;
      5'd16: r = 32'd14668;     5'd17: r = 32'd7334;
      5'd18: r = 32'd3667;      5'd19: r = 32'd1833;
      5'd20: r = 32'd917;       5'd21: r = 32'd458;
      5'd22: r = 32'd229;       5'd23: r = 32'd115;
      default: r = 32'd0;
    endcase
    return r;
  endfunction
endpackage

### sv/ictf_cordic.sv
// Vectoring CORDIC giving atan2(a, z) + 180 degrees in Q24, one step a cycle
module ictf_cordic import ictf_pkg::*; #(
  parameter int Iterations = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] a,
  input  logic signed [15:0] z,
  output logic               done,
  output logic signed [35:0] angle
);
  localparam int CntW = $clog2(Iterations + 1);
  // 16-bit inputs scaled by 2^30; growth below 2 bits
  logic signed [48:0] x, y;
  logic signed [35:0] acc;
  logic [CntW-1:0] cnt;
  logic busy;
  logic [4:0] idx;

  assign idx = 5'(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        if (z < 0) begin
          x   <= -($signed({{33{z[15]}}, z}) <<< 30);
          y   <= -($signed({{33{a[15]}}, a}) <<< 30);
          acc <= (a >= 0) ? 36'sd3019898880 : -36'sd3019898880;
        end else begin
          x   <= $signed({{33{z[15]}}, z}) <<< 30;
          y   <= $signed({{33{a[15]}}, a}) <<< 30;
          acc <= '0;
        end
      end else if (busy) begin
        if (cnt == CntW'(Iterations) || idx >= 5'(TableSize)) begin
          busy  <= 1'b0;
          done  <= 1'b1;
          angle <= acc + 36'sd3019898880;
        end else begin
          cnt <= cnt + 1'b1;
          if (y > 0) begin
            x   <= x + (y >>> idx);
            y   <= y - (x >>> idx);
            acc <= acc + $signed({4'd0, atan_q24(idx)});
          end else if (y < 0) begin
            x   <= x - (y >>> idx);
            y   <= y + (x >>> idx);
            acc <= acc - $signed({4'd0, atan_q24(idx)});
          end
        end
      end
    end
  end
endmodule

### sv/ictf_serial_mul.sv
// Shift-add multiplier, one multiplier bit a cycle
module ictf_serial_mul #(
  parameter int AW = 40,
  parameter int BW = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [AW-1:0]     a,
  input  logic [BW-1:0]     b,
  output logic              done,
  output logic [AW+BW-1:0]  p
);
  localparam int CW = $clog2(BW + 1);
  logic [AW+BW-1:0] mcand;
  logic [BW-1:0] mplier;
  logic [CW-1:0] cnt;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        mcand  <= {{BW{1'b0}}, a};
        mplier <= b;
        p      <= '0;
      end else if (busy) begin
        if (mplier[0]) p <= p + mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (cnt == CW'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### sv/ictf_serial_div.sv
// Restoring divider, one quotient bit a cycle
module ictf_serial_div #(
  parameter int NW = 60,
  parameter int DW = 28
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [DW:0] rem;
  logic [DW:0] trial;
  logic [CW-1:0] cnt;
  logic busy;

  assign trial = {rem[DW-1:0], quo[NW-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= num;
      end else if (busy) begin
        if (!trial[DW]) begin
          rem <= trial;
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= {rem[DW-1:0], quo[NW-1]};
          quo <= {quo[NW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### sv/imu_complementary_tilt_filter.sv
// Top level of the complementary pitch and roll tilt filter
// Usage:
//   s_axis carries one raw IMU sample per request; m_axis carries the
//   filtered pitch and roll. cfg_we/cfg_index/cfg_data write blend_weight
//   (index 0) and gyro_dps_per_count (index 1). The user writes them only
//   while the block is idle; the block itself does not enforce this. Each axis
//   runs in turn through a bit-serial multiplier (scale times gyro, then
//   times elapsed time), a bit-serial divider, a vectoring CORDIC and
//   two more passes through the serial multiplier for the blend. One
//   sample is in flight at a time: a new request is not taken until the
//   result of the last one has been accepted on m_axis.
//   s_axis_tready is low while a sample is being worked on or its result
//   waits; when the receiver stalls the result holds on m_axis.
//   Reset clears both angles to zero and loads the default blend weight
//   and gyro scale.
module imu_complementary_tilt_filter import ictf_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int ATAN_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_us, zero pad
  input  logic [103:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pitch_deg, roll_deg
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);
  localparam int Sh = 24 - ANGLE_FRAC_BITS;
  localparam int DenW = 20 + Sh;
  localparam logic [DenW-1:0] Den = DenW'(64'd1000000 << Sh);
  localparam logic signed [63:0] Max32 = 64'sd2147483647;
  localparam logic signed [63:0] Min32 = -64'sd2147483648;

  logic [15:0] blend_weight;
  logic [23:0] gyro_dps_per_count;
  logic signed [31:0] pitch_angle, roll_angle;
  logic signed [15:0] ax, ay, az, g;
  logic [19:0] us;
  logic axis;
  state_t state, state_next;
  logic [1:0] phase;

  logic m1_start, m1_done, dv_start, dv_done, cd_start, cd_done;
  logic [59:0] m1_p, dv_q;
  logic [39:0] m1_a;
  logic [19:0] m1_b;
  logic g_neg;
  logic [15:0] gx_mag, g_mag;
  logic signed [35:0] cd_ang;
  logic signed [63:0] prop, tilt, sum;
  logic signed [63:0] delta;
  logic signed [63:0] rs;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight       <= 16'd64225;
      gyro_dps_per_count <= 24'd256140;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) blend_weight <= cfg_data[15:0];
      else gyro_dps_per_count <= cfg_data;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_axis_tvalid) state_next = ST_GMUL;
      ST_GMUL:   if (m1_done && phase == 2'd1) state_next = ST_GDIV;
      ST_GDIV:   if (dv_done) state_next = ST_CORDIC;
      ST_CORDIC: if (cd_done) state_next = ST_BLEND;
      ST_BLEND:  if (m1_done && phase == 2'd3) state_next = axis ? ST_OUT : ST_GMUL;
      ST_OUT:    if (m_axis_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    m_axis_tvalid = (state == ST_OUT);
  end

  assign m_axis_tdata = {roll_angle, pitch_angle};
  assign delta = g_neg ? -$signed({4'd0, dv_q}) : $signed({4'd0, dv_q});
  assign gx_mag = s_axis_tdata[63] ? 16'(~s_axis_tdata[63:48] + 16'd1) : s_axis_tdata[63:48];
  assign g_mag = g[15] ? 16'($unsigned(~g) + 16'd1) : $unsigned(g);

  function automatic logic signed [63:0] sat(input logic signed [63:0] v);
    if (v > Max32) return Max32;
    if (v < Min32) return Min32;
    return v;
  endfunction

  ictf_serial_mul #(.AW(40), .BW(20)) u_mul (
    .clk, .rst, .start(m1_start), .a(m1_a), .b(m1_b), .done(m1_done), .p(m1_p)
  );
  ictf_serial_div #(.NW(60), .DW(DenW)) u_div (
    .clk, .rst, .start(dv_start), .num(m1_p + 60'(Den >> 1)), .den(Den),
    .done(dv_done), .quo(dv_q)
  );
  ictf_cordic #(.Iterations(ATAN_ITERATIONS)) u_cordic (
    .clk, .rst, .start(cd_start), .a(axis ? ay : ax), .z(az),
    .done(cd_done), .angle(cd_ang)
  );

  assign rs = (64'(cd_ang) + ((Sh > 0) ? (64'sd1 <<< (Sh - 1)) : 64'sd0)) >>> Sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pitch_angle <= '0;
      roll_angle  <= '0;
      m1_start    <= 1'b0;
      dv_start    <= 1'b0;
      cd_start    <= 1'b0;
    end else begin
      state    <= state_next;
      m1_start <= 1'b0;
      dv_start <= 1'b0;
      cd_start <= 1'b0;
      unique case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          ax    <= s_axis_tdata[15:0];
          ay    <= s_axis_tdata[31:16];
          az    <= s_axis_tdata[47:32];
          us    <= s_axis_tdata[99:80];
          axis  <= 1'b0;
          g_neg <= s_axis_tdata[63];
          g     <= s_axis_tdata[79:64];
          phase <= 2'd0;
          m1_a  <= {16'd0, gyro_dps_per_count};
          m1_b  <= {4'd0, gx_mag};
          m1_start <= 1'b1;
        end
        ST_GMUL: if (m1_done) begin
          if (phase == 2'd0) begin
            phase <= 2'd1;
            m1_a  <= m1_p[39:0];
            m1_b  <= us;
            m1_start <= 1'b1;
          end else begin
            dv_start <= 1'b1;
          end
        end
        ST_GDIV: if (dv_done) begin
          prop <= sat(64'(axis ? roll_angle : pitch_angle) + delta);
          cd_start <= 1'b1;
        end
        ST_CORDIC: if (cd_done) begin
          tilt  <= rs;
          phase <= 2'd2;
          m1_a  <= 40'(prop);
          m1_b  <= 20'(blend_weight);
          m1_start <= 1'b1;
        end
        ST_BLEND: if (m1_done) begin
          if (phase == 2'd2) begin
            sum   <= $signed({4'd0, m1_p})
                     - (prop[63] ? ($signed({44'd0, blend_weight}) <<< 40) : 64'sd0);
            phase <= 2'd3;
            m1_a  <= 40'(tilt);
            m1_b  <= 20'(17'h10000 - {1'b0, blend_weight});
            m1_start <= 1'b1;
          end else begin
            if (axis) roll_angle <= 32'(sat((sum + $signed(64'(m1_p[59:0])) -
              (tilt[63] ? ($signed(64'(17'h10000 - {1'b0, blend_weight})) <<< 40)
              : 64'sd0) + 64'sd32768) >>> 16));
            else pitch_angle <= 32'(sat((sum + $signed(64'(m1_p[59:0])) -
              (tilt[63] ? ($signed(64'(17'h10000 - {1'b0, blend_weight})) <<< 40)
              : 64'sd0) + 64'sd32768) >>> 16));
            if (!axis) begin
              axis  <= 1'b1;
              phase <= 2'd0;
              g_neg <= ~g[15] && (g != 0);
              m1_a  <= {16'd0, gyro_dps_per_count};
              m1_b  <= {4'd0, g_mag};
              m1_start <= 1'b1;
            end
          end
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end
endmodule

### sv/ictf_checker.sv
// Port-level checker for the tilt filter, bound to the top level
`include "imu_complementary_tilt_filter_assert.svh"
module ictf_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [63:0] m_axis_tdata
);
  `ICTF_ASSERT_IMPL(no_take_while_out, m_axis_tvalid, !s_axis_tready)
  `ICTF_ASSERT_NEXT(out_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `ICTF_ASSERT_NEXT(busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid)
endmodule

bind imu_complementary_tilt_filter ictf_checker u_ictf_checker (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

### verif/testbench.sv
// Self-checking testbench for the complementary pitch and roll tilt filter
`timescale 1ns / 100ps
module testbench import ictf_pkg::*;;

  localparam logic CFG_BLEND_WEIGHT = 1'b0;
  localparam logic CFG_GYRO_SCALE   = 1'b1;
  localparam int   LIMIT_CYCLES     = 6000000;
  localparam int   SETTLE_CYCLES    = 800;

  typedef struct packed {
    logic [19:0] elapsed_us;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_x;
    logic signed [15:0] accel_z;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_x;
  } imu_sample_t;

  typedef struct packed {
    logic signed [31:0] roll_deg;
    logic signed [31:0] pitch_deg;
  } tilt_angles_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [23:0] cfg_data = '0;

  imu_sample_t  pending_samples[$];
  tilt_angles_t expected_angles[$];

  logic [15:0] weight_q16 = 16'd64225;
  logic [23:0] dps_q24 = 24'd256140;
  logic signed [31:0] pitch_state = '0;
  logic signed [31:0] roll_state = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_trigger = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  imu_complementary_tilt_filter dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_half_up(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // atan2(a, z) + 180 degrees, Q24
  function automatic longint accel_tilt_q24(longint a, longint z);
    longint x;
    longint y;
    longint ang;
    longint dx;
    longint dy;
    x = z <<< 30;
    y = a <<< 30;
    ang = 0;
    if (x < 0) begin
      ang = (y >= 0) ? longint'(Q24Deg180) : -longint'(Q24Deg180);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        ang = ang + longint'(atan_q24(5'(i)));
      end else if (y < 0) begin
        x = x - dx;
        y = y + dy;
        ang = ang - longint'(atan_q24(5'(i)));
      end
    end
    return ang + longint'(Q24Deg180);
  endfunction

  function automatic longint gyro_step(longint g, longint us);
    longint num;
    longint den;
    longint mag;
    longint q;
    num = g * longint'(dps_q24) * us;
    den = 64'sd1000000 <<< 8;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [31:0] blend_axis(logic signed [31:0] angle, longint g,
                                                   longint us, longint a, longint z);
    longint prop;
    longint tilt;
    longint w;
    prop = sat32(longint'(angle) + gyro_step(g, us));
    tilt = round_half_up(accel_tilt_q24(a, z), 8);
    w = longint'(weight_q16);
    return 32'(sat32(round_half_up(w * prop + (65536 - w) * tilt, 16)));
  endfunction

  task automatic predict_angles(imu_sample_t s);
    tilt_angles_t r;
    pitch_state = blend_axis(pitch_state, longint'(s.gyro_x), longint'(s.elapsed_us),
                             longint'(s.accel_x), longint'(s.accel_z));
    roll_state = blend_axis(roll_state, -longint'(s.gyro_y), longint'(s.elapsed_us),
                            longint'(s.accel_y), longint'(s.accel_z));
    r.pitch_deg = pitch_state;
    r.roll_deg = roll_state;
    expected_angles.push_back(r);
  endtask

  // driver: predict on acceptance, then offer the next request
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_angles(imu_sample_t'(s_axis_tdata[99:0]));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata <= {4'h0, pending_samples.pop_front()};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= 3000;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    tilt_angles_t got;
    tilt_angles_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_angles.pop_front();
        if (got.pitch_deg !== want.pitch_deg || got.roll_deg !== want.roll_deg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch pitch exp %0d got %0d, roll exp %0d got %0d",
                     want.pitch_deg, got.pitch_deg, want.roll_deg, got.roll_deg);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [15:0] pick16();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic imu_sample_t random_sample();
    imu_sample_t s;
    s.accel_x = pick16();
    s.accel_y = pick16();
    s.accel_z = pick16();
    s.gyro_x = pick16();
    s.gyro_y = pick16();
    case ($urandom_range(9))
      0: s.elapsed_us = 20'hFFFFF;
      1: s.elapsed_us = 20'(999999);
      2: s.elapsed_us = 20'($urandom);
      3: s.elapsed_us = '0;
      default: s.elapsed_us = 20'($urandom_range(5000));
    endcase
    return s;
  endfunction

  function automatic imu_sample_t make_sample(int ax, int ay, int az, int gx, int gy, int us);
    imu_sample_t s;
    s.accel_x = 16'(ax);
    s.accel_y = 16'(ay);
    s.accel_z = 16'(az);
    s.gyro_x = 16'(gx);
    s.gyro_y = 16'(gy);
    s.elapsed_us = 20'(us);
    return s;
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_angles.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [23:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BLEND_WEIGHT) weight_q16 = value[15:0];
    else dps_q24 = value;
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] weights[8];
    logic [23:0] scales[8];
    weights = '{16'd64225, 16'd0, 16'hFFFF, 16'd32768, 16'd64225, 16'd1, 16'hFFFF, 16'd0};
    scales = '{24'd256140, 24'hFFFFFF, 24'd0, 24'd256140, 24'hFFFFFF, 24'd1, 24'd256140,
               24'hFFFFFF};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    pending_samples.push_back(make_sample(0, 0, 0, 0, 0, 0));
    pending_samples.push_back(make_sample(0, 0, 16384, 0, 0, 1000));
    pending_samples.push_back(make_sample(0, 0, -16384, 0, 0, 1000));
    pending_samples.push_back(make_sample(16384, -16384, 0, 0, 0, 1000));
    pending_samples.push_back(make_sample(-16384, 16384, 0, 0, 0, 1000));
    pending_samples.push_back(make_sample(1000, -1000, 1000, 0, 0, 1000));
    pending_samples.push_back(make_sample(-1000, 1000, -1000, 0, 0, 1000));
    pending_samples.push_back(make_sample(-32768, -32768, -32768, -32768, -32768, 999999));
    pending_samples.push_back(make_sample(32767, 32767, 32767, 32767, 32767, 999999));
    pending_samples.push_back(make_sample(32767, -32768, -32768, 32767, -32768, 1048575));
    pending_samples.push_back(make_sample(0, 0, 1, 32767, -32768, 1048575));
    pending_samples.push_back(make_sample(0, 0, 1, 32767, -32768, 1048575));
    pending_samples.push_back(make_sample(0, 0, 1, -32768, 32767, 1048575));
    pending_samples.push_back(make_sample(0, 0, 1, -32768, 32767, 1048575));
    pending_samples.push_back(make_sample(1, -1, 32767, 100, -100, 1));
    pending_samples.push_back(make_sample(-1, 1, -32768, -100, 100, 1));
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_BLEND_WEIGHT, {8'h00, weights[p]});
      write_reg(CFG_GYRO_SCALE, scales[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      if (p == 1) hold_trigger = hold_trigger + 1;
      for (int n = 0; n < 242; n++) pending_samples.push_back(random_sample());
      wait_drained();
    end

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

### files.f
+incdir+sv
sv/ictf_pkg.sv
sv/ictf_cordic.sv
sv/ictf_serial_mul.sv
sv/ictf_serial_div.sv
sv/imu_complementary_tilt_filter.sv
sv/ictf_checker.sv
verif/testbench.sv
